@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Field widths, status and opcode codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

	localparam int BLK_W       = 12;    // block number field
	localparam int CNT_W       = 13;    // block counts and limits
	localparam int BLOCK_SPAN  = 4096;  // range of the block number field
	localparam int DIV_SH      = 20;    // reciprocal scale for block/word split

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_FREE_AGAIN = 2'd2,
		ST_RANGE      = 2'd3
	} status_t;

	typedef enum logic {
		CFG_TOTAL    = 1'b0,
		CFG_RESERVED = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV1,
		S_DIV2,
		S_PREP,
		S_SCAN,
		S_FREE_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic prep;
		logic scan_init;
		logic scan;
		logic free_chk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_alloc;
		logic full_now;
		logic range_err;
		logic found;
		logic exhausted;
	} sts_t;

endpackage

@@ design/bba_if.sv @@
// ----------------------------------------------------------------------------
// bba_if: channel interfaces of the bitmap block allocator
// Request, response and configuration write channels, each valid/ready.
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*;;
	logic             valid;
	logic             ready;
	op_t              op;
	logic [BLK_W-1:0] block;

	modport source (output valid, op, block, input ready);
	modport sink (input valid, op, block, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] block_out;
	status_t          status;

	modport source (output valid, block_out, status, input ready);
	modport sink (input valid, block_out, status, output ready);
endinterface

interface bba_cfg_if import bba_pkg::*;;
	logic             valid;
	logic             ready;
	cfg_idx_t         index;
	logic [CNT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl: allocator sequencer
// Runs the clearing pass after reset, then steps each request through the
// block split, the bitmap scan or bit check, and the response register.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_DIV1;
				end
			end
			S_DIV1: state_nxt = S_DIV2;
			S_DIV2: state_nxt = S_PREP;
			S_PREP: begin
				cmd.prep = 1'b1;
				if (sts.is_alloc) begin
					if (sts.full_now) begin
						state_nxt = S_DONE;
					end else begin
						cmd.scan_init = 1'b1;
						state_nxt     = S_SCAN;
					end
				end else begin
					state_nxt = sts.range_err ? S_DONE : S_FREE_CHK;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.found || sts.exhausted) begin
					state_nxt = S_DONE;
				end
			end
			S_FREE_CHK: begin
				cmd.free_chk = 1'b1;
				state_nxt    = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_vld_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign out_valid = out_vld_q;

endmodule

@@ design/bba_dpath.sv @@
// ----------------------------------------------------------------------------
// bba_dpath: allocator datapath
// Configuration registers, bitmap memory with clearing counter, block to
// word/bit split by reciprocal multiply, pipelined word scan with
// first-free search, and the result and output registers.
// ----------------------------------------------------------------------------
module bba_dpath import bba_pkg::*; #(
	parameter int MAX_BLOCKS    = 4096,
	parameter int MAP_WORD_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  op_t              in_op,
	input  logic [BLK_W-1:0] in_block,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CNT_W-1:0] cfg_data,
	output logic [BLK_W-1:0] out_block,
	output status_t          out_status
);

	localparam int MAP_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(MAP_WORD_BITS);
	localparam int CAP       = (MAX_BLOCKS < BLOCK_SPAN) ? MAX_BLOCKS : BLOCK_SPAN;
	localparam logic [CNT_W-1:0]  LIM_CAP = CNT_W'(CAP);
	localparam logic [CNT_W-1:0]  WBITS   = CNT_W'(MAP_WORD_BITS);
	localparam logic [WW-1:0]     LAST_W  = WW'(MAP_WORDS - 1);
	localparam logic [DIV_SH-1:0] RECIP   = DIV_SH'((1 << DIV_SH) / MAP_WORD_BITS);

	// configuration
	logic [CNT_W-1:0] total_q, resv_q, lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= CNT_W'(BLOCK_SPAN);
			resv_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL:    total_q <= cfg_data;
				CFG_RESERVED: resv_q  <= cfg_data;
			endcase
		end
	end

	assign lim = (total_q > LIM_CAP) ? LIM_CAP : total_q;

	// request latch
	op_t              op_q;
	logic [BLK_W-1:0] blk_q;
	logic [CNT_W-1:0] x_q;
	logic [CNT_W-1:0] blk_ext;

	assign blk_ext = {1'b0, blk_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= in_op;
			blk_q <= in_block;
			x_q   <= (in_op == OP_FREE) ? {1'b0, in_block} : resv_q;
		end
	end

	// word/bit split: estimate by reciprocal, then one correction step
	logic [CNT_W+DIV_SH-1:0] prod_s1;
	logic [CNT_W-1:0]        q_est, rem, q_q, r_q;
	logic [2*CNT_W-1:0]      qw_full;

	assign q_est   = prod_s1[DIV_SH +: CNT_W];
	assign qw_full = q_est * WBITS;
	assign rem     = x_q - qw_full[CNT_W-1:0];

	always_ff @(posedge clk) begin
		prod_s1 <= x_q * RECIP;
		if (rem >= WBITS) begin
			q_q <= q_est + 1'b1;
			r_q <= rem - WBITS;
		end else begin
			q_q <= q_est;
			r_q <= rem;
		end
	end

	// bitmap memory
	logic [MAP_WORD_BITS-1:0] mem_q [MAP_WORDS];
	logic [MAP_WORD_BITS-1:0] rdata_q, wd;
	logic [WW-1:0]            wa, ra, clr_w_q;
	logic                     we;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rdata_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_w_q <= '0;
		end else if (cmd.clear) begin
			clr_w_q <= clr_w_q + 1'b1;
		end
	end

	// scan: issue one word read a cycle, examine the word read last cycle
	logic [WW-1:0]    iss_w_q, ex_w_s1;
	logic [CNT_W-1:0] iss_base_q, ex_base_s1;
	logic             ex_vld_s1, issue;

	assign issue = cmd.scan && (iss_base_q < lim);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			iss_w_q    <= q_q[WW-1:0];
			iss_base_q <= x_q - r_q;
		end else if (issue) begin
			iss_w_q    <= iss_w_q + 1'b1;
			iss_base_q <= iss_base_q + WBITS;
		end
		ex_w_s1    <= iss_w_q;
		ex_base_s1 <= iss_base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_vld_s1 <= 1'b0;
		end else begin
			ex_vld_s1 <= issue;
		end
	end

	assign ra = issue ? iss_w_q : q_q[WW-1:0];

	// window of usable bits in the examined word
	logic [CNT_W-1:0]         lo, hi, span;
	logic [MAP_WORD_BITS-1:0] win, free_v;
	logic [BW-1:0]            idx;
	logic                     any_free, last_word;

	always_comb begin
		lo   = (ex_base_s1 < resv_q) ? (resv_q - ex_base_s1) : '0;
		span = lim - ex_base_s1;
		hi   = (span > WBITS) ? WBITS : span;
		for (int i = 0; i < MAP_WORD_BITS; i++) begin
			win[i] = (CNT_W'(i) >= lo) && (CNT_W'(i) < hi);
		end
		free_v = ~rdata_q & win;
	end

	// lowest free bit
	always_comb begin
		idx = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (free_v[i]) begin
				idx = BW'(i);
			end
		end
	end

	assign any_free  = |free_v;
	assign last_word = (ex_base_s1 + WBITS) >= lim;

	logic             fbit;
	logic [CNT_W-1:0] found_blk;

	assign fbit      = rdata_q[r_q[BW-1:0]];
	assign found_blk = ex_base_s1 + CNT_W'(idx);

	assign sts.clr_last  = (clr_w_q == LAST_W);
	assign sts.is_alloc  = (op_q == OP_ALLOC);
	assign sts.full_now  = (resv_q >= lim);
	assign sts.range_err = (blk_ext < resv_q) || (blk_ext >= lim);
	assign sts.found     = ex_vld_s1 && any_free;
	assign sts.exhausted = ex_vld_s1 && !any_free && last_word;

	// write port
	always_comb begin
		we = 1'b0;
		wa = clr_w_q;
		wd = '0;
		priority if (cmd.clear) begin
			we = 1'b1;
		end else if (cmd.scan && sts.found) begin
			we = 1'b1;
			wa = ex_w_s1;
			wd = rdata_q | (MAP_WORD_BITS'(1) << idx);
		end else if (cmd.free_chk && fbit) begin
			we = 1'b1;
			wa = q_q[WW-1:0];
			wd = rdata_q & ~(MAP_WORD_BITS'(1) << r_q[BW-1:0]);
		end
	end

	// result and output registers
	logic [BLK_W-1:0] res_blk_q, out_blk_q;
	status_t          res_st_q, out_st_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			// preload the failure answer; a hit below overwrites it
			if (op_q == OP_ALLOC) begin
				res_blk_q <= '0;
				res_st_q  <= ST_FULL;
			end else begin
				res_blk_q <= blk_q;
				res_st_q  <= ST_RANGE;
			end
		end else if (cmd.scan && sts.found) begin
			res_blk_q <= found_blk[BLK_W-1:0];
			res_st_q  <= ST_OK;
		end else if (cmd.free_chk) begin
			res_st_q <= fbit ? ST_OK : ST_FREE_AGAIN;
		end
		if (cmd.out_load) begin
			out_blk_q <= res_blk_q;
			out_st_q  <= res_st_q;
		end
	end

	assign out_block  = out_blk_q;
	assign out_status = out_st_q;

endmodule

@@ design/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit disk block allocator
// Keeps one in-use bit per block and serves allocate and free requests.
// ----------------------------------------------------------------------------
// Usage:
//   req carries op (allocate or free) and block; rsp returns block_out and
//   status for every request, in order. cfg writes total_blocks (index 0)
//   and reserved_blocks (index 1); write it only while the block is idle.
// Timing:
//   One request is worked on at a time. A free passes the block split and the
//   bit check before rsp valid; one whose block is out of range skips the bit
//   check. An allocate examines bitmap words after the block split, one
//   word per cycle on the single memory read port, starting at the word that
//   holds reserved_blocks, until a free bit is found or the usable range ends;
//   with no usable range it skips the scan. The next req is taken the cycle
//   after the result moves into the output register.
// Reset:
//   Registers take their reset values, then a clearing pass writes one
//   bitmap word per cycle until all MAX_BLOCKS / MAP_WORD_BITS words (rounded
//   up) are clear, with req.ready low; cfg writes are taken throughout.
// Stall:
//   A stalled rsp holds its payload; one more request is accepted and
//   finished behind it and then waits for the output register.
// ----------------------------------------------------------------------------
module bitmap_block_allocator import bba_pkg::*; #(
	parameter int MAX_BLOCKS    = 4096,
	parameter int MAP_WORD_BITS = 64
) (
	input logic         clk,
	input logic         arst_n,
	bba_req_if.sink     req,
	bba_rsp_if.source   rsp,
	bba_cfg_if.sink     cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dpath #(
		.MAX_BLOCKS    (MAX_BLOCKS),
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (req.op),
		.in_block   (req.block),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.out_block  (rsp.block_out),
		.out_status (rsp.status)
	);

endmodule

@@ design/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker: port-level checks of the bitmap block allocator
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [BLK_W-1:0] rsp_block_out,
	input status_t          rsp_status
);

	// one request at a time: ready drops right after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in progress");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_FULL) |-> (rsp_block_out == '0))
		else $error("no-free-block response with nonzero block number");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_block_out) && $stable(rsp_status))
		else $error("response payload changed while stalled");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_block_out (rsp.block_out),
	.rsp_status    (rsp.status)
);
